// ===== hw/rtl/spom_pkg.sv =====
`default_nettype none

package spom_pkg;

    // Widths fixed by the item fields and registers
    localparam int VALUE_W   = 32;
    localparam int IDX_W     = 3;
    localparam int SIZE_W    = 4;
    localparam int CFG_IDX_W = 4;
    localparam int COUNT_W   = 7;

    localparam int DEFAULT_MAX_ROWS    = 8;
    localparam int DEFAULT_MAX_COLUMNS = 8;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 4'd1;

    // One complete matrix handed from the loader to the spiral engine
    typedef struct packed {
        logic [SIZE_W-1:0] rows;
        logic [SIZE_W-1:0] cols;
    } job_t;

    // Status the loader needs from the rest of the block
    typedef struct packed {
        logic job_pending;
        logic engine_busy;
    } load_status_t;

    typedef enum logic {
        BK_IDLE,
        BK_WALK
    } back_state_t;

    typedef enum logic [1:0] {
        DIR_RIGHT,
        DIR_DOWN,
        DIR_LEFT,
        DIR_UP
    } dir_t;

    // Zero counts as one, anything above the maximum saturates
    function automatic logic [SIZE_W-1:0] eff_size(
        input logic [SIZE_W-1:0] v,
        input int unsigned       maxv
    );
        logic [SIZE_W-1:0] r;
        if (v == '0) begin
            r = SIZE_W'(1);
        end else if (32'(v) > maxv) begin
            r = SIZE_W'(maxv);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/spom_front.sv =====
`default_nettype none

module spom_front #(
    parameter int MAX_ROWS    = spom_pkg::DEFAULT_MAX_ROWS,
    parameter int MAX_COLUMNS = spom_pkg::DEFAULT_MAX_COLUMNS,
    localparam int DEPTH      = MAX_ROWS * MAX_COLUMNS,
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [spom_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [spom_pkg::SIZE_W-1:0]      cfg_data,
    input  wire logic                             element_valid,
    output logic                                  element_stall,
    input  wire logic [spom_pkg::VALUE_W-1:0]     element_value,
    input  wire spom_pkg::load_status_t           status,
    output logic                                  wr_en,
    output logic [ADDR_W-1:0]                     wr_addr,
    output logic [spom_pkg::VALUE_W-1:0]          wr_data,
    output logic                                  job_push,
    output spom_pkg::job_t                        job
);

    logic [spom_pkg::SIZE_W-1:0] rows_reg, rows_next;
    logic [spom_pkg::SIZE_W-1:0] cols_reg, cols_next;
    logic [spom_pkg::IDX_W-1:0]  load_row_reg, load_row_next;
    logic [spom_pkg::IDX_W-1:0]  load_col_reg, load_col_next;
    logic                        accept;
    logic                        col_end;
    logic                        row_end;

    assign cfg_ready     = 1'b1;
    // Hold off new elements until the stored matrix has been read out
    assign element_stall = status.job_pending | status.engine_busy;
    assign accept        = element_valid & ~element_stall;

    assign col_end = ({1'b0, load_col_reg} == cols_reg - spom_pkg::SIZE_W'(1));
    assign row_end = ({1'b0, load_row_reg} == rows_reg - spom_pkg::SIZE_W'(1));

    assign wr_en    = accept;
    assign wr_addr  = ADDR_W'(32'(load_row_reg) * MAX_COLUMNS + 32'(load_col_reg));
    assign wr_data  = element_value;
    assign job_push = accept & col_end & row_end;
    assign job.rows = rows_reg;
    assign job.cols = cols_reg;

    always_comb
    begin
        rows_next     = rows_reg;
        cols_next     = cols_reg;
        load_row_next = load_row_reg;
        load_col_next = load_col_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                spom_pkg::CFG_ROW_COUNT:
                begin
                    rows_next     = spom_pkg::eff_size(cfg_data, MAX_ROWS);
                    load_row_next = '0;
                    load_col_next = '0;
                end
                spom_pkg::CFG_COLUMN_COUNT:
                begin
                    cols_next     = spom_pkg::eff_size(cfg_data, MAX_COLUMNS);
                    load_row_next = '0;
                    load_col_next = '0;
                end
                default:
                begin
                    // unknown register: drop the write
                end
            endcase
        end else if (accept) begin
            if (col_end) begin
                load_col_next = '0;
                load_row_next = row_end ? '0 : load_row_reg + spom_pkg::IDX_W'(1);
            end else begin
                load_col_next = load_col_reg + spom_pkg::IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rows_reg     <= spom_pkg::eff_size(spom_pkg::SIZE_RESET, MAX_ROWS);
            cols_reg     <= spom_pkg::eff_size(spom_pkg::SIZE_RESET, MAX_COLUMNS);
            load_row_reg <= '0;
            load_col_reg <= '0;
        end else begin
            rows_reg     <= rows_next;
            cols_reg     <= cols_next;
            load_row_reg <= load_row_next;
            load_col_reg <= load_col_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/spom_job_fifo.sv =====
`default_nettype none

module spom_job_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire spom_pkg::job_t push_job,
    input  wire logic           pop,
    output logic                job_valid,
    output spom_pkg::job_t      job
);

    spom_pkg::job_t entry_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    logic           do_push;
    logic           do_pop;

    assign job_valid = (count_reg != 2'd0);
    assign job       = entry_reg[rd_ptr_reg];
    assign do_push   = push & (count_reg != 2'd2);
    assign do_pop    = pop & job_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/spom_back.sv =====
`default_nettype none

module spom_back #(
    parameter int MAX_ROWS    = spom_pkg::DEFAULT_MAX_ROWS,
    parameter int MAX_COLUMNS = spom_pkg::DEFAULT_MAX_COLUMNS,
    localparam int DEPTH      = MAX_ROWS * MAX_COLUMNS,
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          wr_en,
    input  wire logic [ADDR_W-1:0]             wr_addr,
    input  wire logic [spom_pkg::VALUE_W-1:0]  wr_data,
    input  wire logic                          job_valid,
    input  wire spom_pkg::job_t                job,
    output logic                               job_pop,
    output logic                               busy,
    output logic                               result_valid,
    input  wire logic                          result_stall,
    output logic [spom_pkg::VALUE_W-1:0]       out_value,
    output logic [spom_pkg::IDX_W-1:0]         out_row,
    output logic [spom_pkg::IDX_W-1:0]         out_column,
    output logic                               last_of_matrix
);

    localparam int IW = spom_pkg::IDX_W;

    logic [spom_pkg::VALUE_W-1:0] store_mem [DEPTH];

    spom_pkg::back_state_t state_reg, state_next;
    spom_pkg::dir_t        dir_reg, dir_next;
    logic [IW-1:0] r_reg, r_next, c_reg, c_next;
    logic [IW-1:0] top_reg, top_next, bottom_reg, bottom_next;
    logic [IW-1:0] left_reg, left_next, right_reg, right_next;
    logic [spom_pkg::COUNT_W-1:0] remain_reg, remain_next;

    logic          valid_reg, valid_next;
    logic [IW-1:0] row_out_reg, col_out_reg;
    logic          last_out_reg;
    logic [spom_pkg::VALUE_W-1:0] value_out_reg;

    logic              advance;
    logic              issue;
    logic [ADDR_W-1:0] rd_addr;

    assign advance = ~valid_reg | ~result_stall;
    assign issue   = (state_reg == spom_pkg::BK_WALK) & advance;
    assign job_pop = (state_reg == spom_pkg::BK_IDLE) & job_valid;
    assign busy    = (state_reg == spom_pkg::BK_WALK);
    assign rd_addr = ADDR_W'(32'(r_reg) * MAX_COLUMNS + 32'(c_reg));

    assign result_valid   = valid_reg;
    assign out_value      = value_out_reg;
    assign out_row        = row_out_reg;
    assign out_column     = col_out_reg;
    assign last_of_matrix = last_out_reg;

    always_comb
    begin
        state_next  = state_reg;
        dir_next    = dir_reg;
        r_next      = r_reg;
        c_next      = c_reg;
        top_next    = top_reg;
        bottom_next = bottom_reg;
        left_next   = left_reg;
        right_next  = right_reg;
        remain_next = remain_reg;
        valid_next  = advance ? 1'b0 : valid_reg;

        unique case (state_reg)
            spom_pkg::BK_IDLE:
            begin
                if (job_valid) begin
                    state_next  = spom_pkg::BK_WALK;
                    dir_next    = spom_pkg::DIR_RIGHT;
                    r_next      = '0;
                    c_next      = '0;
                    top_next    = '0;
                    left_next   = '0;
                    bottom_next = IW'(job.rows - spom_pkg::SIZE_W'(1));
                    right_next  = IW'(job.cols - spom_pkg::SIZE_W'(1));
                    remain_next = spom_pkg::COUNT_W'(job.rows)
                                  * spom_pkg::COUNT_W'(job.cols)
                                  - spom_pkg::COUNT_W'(1);
                end
            end
            spom_pkg::BK_WALK:
            begin
                if (issue) begin
                    valid_next  = 1'b1;
                    remain_next = remain_reg - spom_pkg::COUNT_W'(1);
                    if (remain_reg == '0) begin
                        state_next = spom_pkg::BK_IDLE;
                    end
                    // step one cell; at the edge retire the row or column just walked and turn
                    unique case (dir_reg)
                        spom_pkg::DIR_RIGHT:
                        begin
                            if (c_reg != right_reg) begin
                                c_next = c_reg + IW'(1);
                            end else begin
                                top_next = top_reg + IW'(1);
                                r_next   = r_reg + IW'(1);
                                dir_next = spom_pkg::DIR_DOWN;
                            end
                        end
                        spom_pkg::DIR_DOWN:
                        begin
                            if (r_reg != bottom_reg) begin
                                r_next = r_reg + IW'(1);
                            end else begin
                                right_next = right_reg - IW'(1);
                                c_next     = c_reg - IW'(1);
                                dir_next   = spom_pkg::DIR_LEFT;
                            end
                        end
                        spom_pkg::DIR_LEFT:
                        begin
                            if (c_reg != left_reg) begin
                                c_next = c_reg - IW'(1);
                            end else begin
                                bottom_next = bottom_reg - IW'(1);
                                r_next      = r_reg - IW'(1);
                                dir_next    = spom_pkg::DIR_UP;
                            end
                        end
                        spom_pkg::DIR_UP:
                        begin
                            if (r_reg != top_reg) begin
                                r_next = r_reg - IW'(1);
                            end else begin
                                left_next = left_reg + IW'(1);
                                c_next    = c_reg + IW'(1);
                                dir_next  = spom_pkg::DIR_RIGHT;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = spom_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= spom_pkg::BK_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dir_reg    <= dir_next;
        r_reg      <= r_next;
        c_reg      <= c_next;
        top_reg    <= top_next;
        bottom_reg <= bottom_next;
        left_reg   <= left_next;
        right_reg  <= right_next;
        remain_reg <= remain_next;
        if (issue) begin
            row_out_reg  <= r_reg;
            col_out_reg  <= c_reg;
            last_out_reg <= (remain_reg == '0);
        end
    end

    // Element store: one write port from the loader, one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            store_mem[wr_addr] <= wr_data;
        end
        if (issue) begin
            value_out_reg <= store_mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/spiral_order_matrix_reader_unit.sv =====
// Spiral-order matrix reader.
// Configuration: write row_count (index 0) and column_count (index 1) on the
// cfg channel while the block is idle; zero counts as one, larger values
// saturate at MAX_ROWS / MAX_COLUMNS. A size write drops a partly loaded matrix.
// Input: one element per item on element_value, row-major order. The matrix
// is held in an internal store of MAX_ROWS x MAX_COLUMNS words.
// Output: once the last element is in, every element comes out in clockwise
// spiral order with its row, column and last_of_matrix on the final one.
// Timing: elements load while element_stall is low, results leave while
// result_stall is low. The final element passes the job queue and engine
// state before the output register shows the first result. element_stall
// stays high from the final element until the engine's last store read.
// Reset: row and column counts return to 8 (saturated), load position to
// the first element, no result pending. Store contents are not cleared.
// A stalled result holds its payload; the spiral engine pauses with it.
`default_nettype none

module spiral_order_matrix_reader_unit #(
    parameter int MAX_ROWS    = spom_pkg::DEFAULT_MAX_ROWS,
    parameter int MAX_COLUMNS = spom_pkg::DEFAULT_MAX_COLUMNS
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [spom_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [spom_pkg::SIZE_W-1:0]    cfg_data,
    input  wire logic                           element_valid,
    output logic                                element_stall,
    input  wire logic [spom_pkg::VALUE_W-1:0]   element_value,
    output logic                                result_valid,
    input  wire logic                           result_stall,
    output logic [spom_pkg::VALUE_W-1:0]        out_value,
    output logic [spom_pkg::IDX_W-1:0]          out_row,
    output logic [spom_pkg::IDX_W-1:0]          out_column,
    output logic                                last_of_matrix
);

    localparam int DEPTH  = MAX_ROWS * MAX_COLUMNS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                           wr_en;
    logic [ADDR_W-1:0]              wr_addr;
    logic [spom_pkg::VALUE_W-1:0]   wr_data;
    logic                           job_push;
    spom_pkg::job_t                 push_job;
    logic                           job_valid;
    spom_pkg::job_t                 job;
    logic                           job_pop;
    logic                           engine_busy;
    spom_pkg::load_status_t         status;

    // Loader sees the matrix as in use from completion until the last read
    assign status.job_pending = job_valid;
    assign status.engine_busy = engine_busy;

    // Loader: config registers, load position, store writes
    spom_front #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .element_valid (element_valid),
        .element_stall (element_stall),
        .element_value (element_value),
        .status        (status),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .job_push      (job_push),
        .job           (push_job)
    );

    // Completed matrices wait here for the spiral engine
    spom_job_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_job  (push_job),
        .pop       (job_pop),
        .job_valid (job_valid),
        .job       (job)
    );

    // Spiral engine: walks the bounds, reads the store, drives results
    spom_back #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .wr_en          (wr_en),
        .wr_addr        (wr_addr),
        .wr_data        (wr_data),
        .job_valid      (job_valid),
        .job            (job),
        .job_pop        (job_pop),
        .busy           (engine_busy),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .out_value      (out_value),
        .out_row        (out_row),
        .out_column     (out_column),
        .last_of_matrix (last_of_matrix)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/spom_checker.sv =====
`default_nettype none

module spom_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_ready,
    input  wire logic                           element_stall,
    input  wire logic                           result_valid,
    input  wire logic                           result_stall,
    input  wire logic [spom_pkg::VALUE_W-1:0]   out_value,
    input  wire logic [spom_pkg::IDX_W-1:0]     out_row,
    input  wire logic [spom_pkg::IDX_W-1:0]     out_column,
    input  wire logic                           last_of_matrix
);

    // A stalled result keeps its whole payload
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(out_value)
            && $stable(out_row) && $stable(out_column) && $stable(last_of_matrix))
    else $error("stalled result changed");

    // Mid-spiral, the store is still being read: loading must be held off
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last_of_matrix |-> element_stall)
    else $error("element accepted while spiral still in progress");

    // Configuration is always taken
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
    else $error("cfg_ready dropped");

    // Inside a spiral, a taken result is followed right away by the next one
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && !last_of_matrix |=> result_valid)
    else $error("gap inside a spiral");

endmodule

bind spiral_order_matrix_reader_unit spom_checker u_spom_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_ready      (cfg_ready),
    .element_stall  (element_stall),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .out_value      (out_value),
    .out_row        (out_row),
    .out_column     (out_column),
    .last_of_matrix (last_of_matrix)
);

`default_nettype wire

// ===== tb/spiral_order_checker.sv =====
module spiral_order_checker #(
    parameter int MAX_ROWS    = spom_pkg::DEFAULT_MAX_ROWS,
    parameter int MAX_COLUMNS = spom_pkg::DEFAULT_MAX_COLUMNS
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    input  wire logic                           cfg_ready,
    input  wire logic [spom_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [spom_pkg::SIZE_W-1:0]    cfg_data,
    input  wire logic                           element_valid,
    input  wire logic                           element_stall,
    input  wire logic [spom_pkg::VALUE_W-1:0]   element_value,
    input  wire logic                           result_valid,
    input  wire logic                           result_stall,
    input  wire logic [spom_pkg::VALUE_W-1:0]   out_value,
    input  wire logic [spom_pkg::IDX_W-1:0]     out_row,
    input  wire logic [spom_pkg::IDX_W-1:0]     out_column,
    input  wire logic                           last_of_matrix,
    output int                                  mismatch_count,
    output int                                  cells_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_WORDS = MAX_ROWS * MAX_COLUMNS;

    typedef struct packed {
        logic [spom_pkg::VALUE_W-1:0] value;
        logic [spom_pkg::IDX_W-1:0]   row;
        logic [spom_pkg::IDX_W-1:0]   column;
        logic                         last;
    } spiral_cell_t;

    logic [spom_pkg::VALUE_W-1:0] matrix_words [STORE_WORDS];
    int                           words_loaded;
    logic [spom_pkg::SIZE_W-1:0]  row_code;
    logic [spom_pkg::SIZE_W-1:0]  column_code;
    spiral_cell_t                 spiral_cells_due [$];
    int                           errors = 0;

    function automatic int bounded_size(input logic [spom_pkg::SIZE_W-1:0] code,
                                        input int limit);
        if (code == '0) begin
            return 1;
        end
        if (int'(code) > limit) begin
            return limit;
        end
        return int'(code);
    endfunction

    function automatic void push_cell(input int r, input int c, input int ncols,
                                      input bit is_last);
        spiral_cell_t entry;
        entry.value  = matrix_words[r * ncols + c];
        entry.row    = spom_pkg::IDX_W'(r);
        entry.column = spom_pkg::IDX_W'(c);
        entry.last   = is_last;
        spiral_cells_due.insert(spiral_cells_due.size(), entry);
    endfunction

    // Walk the loaded matrix clockwise, shrinking the bounds after each pass
    function automatic void queue_spiral_walk();
        int nrows;
        int ncols;
        int total;
        int top_r;
        int bottom_r;
        int left_c;
        int right_c;
        int i;
        int n;
        nrows    = bounded_size(row_code, MAX_ROWS);
        ncols    = bounded_size(column_code, MAX_COLUMNS);
        total    = nrows * ncols;
        top_r    = 0;
        bottom_r = nrows - 1;
        left_c   = 0;
        right_c  = ncols - 1;
        n        = 0;
        while (top_r <= bottom_r && left_c <= right_c) begin
            for (i = left_c; i <= right_c; i++) begin
                push_cell(top_r, i, ncols, n == total - 1);
                n++;
            end
            top_r++;
            for (i = top_r; i <= bottom_r; i++) begin
                push_cell(i, right_c, ncols, n == total - 1);
                n++;
            end
            right_c--;
            if (top_r <= bottom_r) begin
                for (i = right_c; i >= left_c; i--) begin
                    push_cell(bottom_r, i, ncols, n == total - 1);
                    n++;
                end
                bottom_r--;
            end
            if (left_c <= right_c) begin
                for (i = bottom_r; i >= top_r; i--) begin
                    push_cell(i, left_c, ncols, n == total - 1);
                    n++;
                end
                left_c++;
            end
        end
    endfunction

    function automatic void report_field(input string field_name,
                                         input logic [spom_pkg::VALUE_W-1:0] want,
                                         input logic [spom_pkg::VALUE_W-1:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, field_name, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        spiral_cell_t due;
        if (!rst_n) begin
            words_loaded = 0;
            row_code     = spom_pkg::SIZE_RESET;
            column_code  = spom_pkg::SIZE_RESET;
            spiral_cells_due.delete();
        end else begin
            if (result_valid && !result_stall) begin
                if (spiral_cells_due.size() == 0) begin
                    errors++;
                    $display({"%0t: unexpected result, expected none, ",
                              "actual value %0h row %0d col %0d"},
                             $time, out_value, out_row, out_column);
                end else begin
                    due = spiral_cells_due.pop_front();
                    report_field("out_value", due.value, out_value);
                    report_field("out_row", spom_pkg::VALUE_W'(due.row),
                                 spom_pkg::VALUE_W'(out_row));
                    report_field("out_column", spom_pkg::VALUE_W'(due.column),
                                 spom_pkg::VALUE_W'(out_column));
                    report_field("last_of_matrix", spom_pkg::VALUE_W'(due.last),
                                 spom_pkg::VALUE_W'(last_of_matrix));
                end
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == spom_pkg::CFG_ROW_COUNT) begin
                    row_code     = cfg_data;
                    words_loaded = 0;
                end else if (cfg_index == spom_pkg::CFG_COLUMN_COUNT) begin
                    column_code  = cfg_data;
                    words_loaded = 0;
                end
            end
            if (element_valid && !element_stall) begin
                if (words_loaded < STORE_WORDS) begin
                    matrix_words[words_loaded] = element_value;
                end
                words_loaded++;
                if (words_loaded >= bounded_size(row_code, MAX_ROWS)
                                    * bounded_size(column_code, MAX_COLUMNS)) begin
                    words_loaded = 0;
                    queue_spiral_walk();
                end
            end
        end
        mismatch_count    <= errors;
        cells_outstanding <= spiral_cells_due.size();
    end

endmodule

// ===== tb/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TB_MAX_ROWS    = spom_pkg::DEFAULT_MAX_ROWS;
    localparam int TB_MAX_COLUMNS = spom_pkg::DEFAULT_MAX_COLUMNS;

    // Any index past the two size registers is ignored by the block
    localparam logic [spom_pkg::CFG_IDX_W-1:0] CFG_FIRST_UNUSED =
        spom_pkg::CFG_COLUMN_COUNT + 1'b1;

    // Cycles to let the spiral engine finish its last store read before a write
    localparam int SETTLE_CYCLES  = 12;
    // Long receiver hold-off, enough for the block to back up onto its input
    localparam int HOLDOFF_CYCLES = 300;
    // Stop offering new matrices once this many items have gone in
    localparam int ITEM_TARGET    = 204;

    logic                           clk           = 1'b0;
    logic                           rst_n         = 1'b0;
    logic                           cfg_valid     = 1'b0;
    logic                           cfg_ready;
    logic [spom_pkg::CFG_IDX_W-1:0] cfg_index     = '0;
    logic [spom_pkg::SIZE_W-1:0]    cfg_data      = '0;
    logic                           element_valid = 1'b0;
    logic                           element_stall;
    logic [spom_pkg::VALUE_W-1:0]   element_value = '0;
    logic                           result_valid;
    logic                           result_stall  = 1'b0;
    logic [spom_pkg::VALUE_W-1:0]   out_value;
    logic [spom_pkg::IDX_W-1:0]     out_row;
    logic [spom_pkg::IDX_W-1:0]     out_column;
    logic                           last_of_matrix;

    int mismatch_count;
    int cells_outstanding;

    // Sender pacing and the current matrix shape as the block sees it
    int burst_left      = 0;
    bit gaps_enabled    = 1'b1;
    bit holdoff_request = 1'b0;
    int items_pushed    = 0;
    int shape_rows      = TB_MAX_ROWS;
    int shape_columns   = TB_MAX_COLUMNS;

    always #5 clk = ~clk;

    spiral_order_matrix_reader_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .element_valid  (element_valid),
        .element_stall  (element_stall),
        .element_value  (element_value),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .out_value      (out_value),
        .out_row        (out_row),
        .out_column     (out_column),
        .last_of_matrix (last_of_matrix)
    );

    spiral_order_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .element_valid     (element_valid),
        .element_stall     (element_stall),
        .element_value     (element_value),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .out_value         (out_value),
        .out_row           (out_row),
        .out_column        (out_column),
        .last_of_matrix    (last_of_matrix),
        .mismatch_count    (mismatch_count),
        .cells_outstanding (cells_outstanding)
    );

    // Mix of full-range words and the corners of the signed range
    function automatic logic [spom_pkg::VALUE_W-1:0] random_word();
        case ($urandom_range(0, 6))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF - $urandom_range(0, 15);
            3:       return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    // Mostly small shapes, sometimes up to the maximum, sometimes zero or oversize
    function automatic logic [spom_pkg::SIZE_W-1:0] pick_size_code();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12) begin
            return spom_pkg::SIZE_W'($urandom_range(1, 4));
        end
        if (r < 16) begin
            return spom_pkg::SIZE_W'($urandom_range(5, 8));
        end
        if (r == 16) begin
            return '0;
        end
        return spom_pkg::SIZE_W'($urandom_range(9, 15));
    endfunction

    // Offer one item; open a gap first when the current burst has run out.
    // Valid stays high across back-to-back items so it never toggles in one step.
    task automatic push_element(input logic [spom_pkg::VALUE_W-1:0] word);
        int gap;
        if (burst_left == 0) begin
            gap = 0;
            if (gaps_enabled) begin
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 25)
                                                  : $urandom_range(0, 4);
            end
            if (gap > 0) begin
                element_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        element_valid <= 1'b1;
        element_value <= word;
        @(posedge clk);
        while (element_stall) @(posedge clk);
        items_pushed++;
    endtask

    // Drop valid and hold until every predicted result has come back,
    // then give the engine time to retire its final store read
    task automatic settle_block();
        element_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (cells_outstanding != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Registers only change on an idle block; the bench drops cfg_valid after each write
    task automatic write_register(input logic [spom_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [spom_pkg::SIZE_W-1:0] data);
        settle_block();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Write a size register and track the effective shape for the stimulus
    task automatic write_size(input logic [spom_pkg::CFG_IDX_W-1:0] idx,
                              input logic [spom_pkg::SIZE_W-1:0] code);
        int eff;
        write_register(idx, code);
        eff = (code == '0) ? 1 : int'(code);
        if (idx == spom_pkg::CFG_ROW_COUNT) begin
            shape_rows = (eff > TB_MAX_ROWS) ? TB_MAX_ROWS : eff;
        end else begin
            shape_columns = (eff > TB_MAX_COLUMNS) ? TB_MAX_COLUMNS : eff;
        end
    endtask

    // Send one whole matrix; request the long hold-off at item holdoff_at
    task automatic push_matrix(input int holdoff_at);
        int i;
        for (i = 0; i < shape_rows * shape_columns; i++) begin
            if (i == holdoff_at) begin
                holdoff_request = 1'b1;
            end
            push_element(random_word());
        end
    endtask

    // Receiver: switch among stall patterns every so often, and on request
    // hold off for a long stretch so the block backs up
    initial begin
        int mode;
        int mode_left;
        int tick;
        mode      = 0;
        mode_left = 0;
        tick      = 0;
        forever begin
            @(posedge clk);
            if (holdoff_request) begin
                holdoff_request = 1'b0;
                result_stall <= 1'b1;
                repeat (HOLDOFF_CYCLES) @(posedge clk);
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 120);
                end
                mode_left--;
                tick++;
                case (mode)
                    0:       result_stall <= 1'b0;
                    1:       result_stall <= ($urandom_range(0, 3) == 0);
                    2:       result_stall <= ($urandom_range(0, 9) < 7);
                    default: result_stall <= ((tick % 4) != 0);
                endcase
            end
        end
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        logic [spom_pkg::VALUE_W-1:0] corner_words [8];
        int choice;
        int part;
        int i;
        corner_words = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
                         32'h0000_0001, 32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0001};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero in both size registers counts as a single element
        write_size(spom_pkg::CFG_ROW_COUNT, 4'd0);
        write_size(spom_pkg::CFG_COLUMN_COUNT, 4'd0);
        push_element(32'h8000_0000);

        // Single row; an oversize column count saturates
        write_size(spom_pkg::CFG_COLUMN_COUNT, 4'd15);
        foreach (corner_words[k]) push_element(corner_words[k]);

        // Single column; an oversize row count saturates
        write_size(spom_pkg::CFG_ROW_COUNT, 4'd9);
        write_size(spom_pkg::CFG_COLUMN_COUNT, 4'd1);
        foreach (corner_words[k]) push_element(~corner_words[k]);

        // Unknown index keeps a partial load, a size write drops it
        write_size(spom_pkg::CFG_ROW_COUNT, 4'd2);
        write_size(spom_pkg::CFG_COLUMN_COUNT, 4'd2);
        push_element(random_word());
        push_element(random_word());
        write_register(CFG_FIRST_UNUSED + spom_pkg::CFG_IDX_W'($urandom_range(0, 13)),
                       spom_pkg::SIZE_W'($urandom));
        push_element(random_word());
        write_size(spom_pkg::CFG_ROW_COUNT, 4'd1);
        push_element(random_word());
        push_element(random_word());

        // Largest matrix fills the whole store
        write_size(spom_pkg::CFG_ROW_COUNT, 4'd8);
        write_size(spom_pkg::CFG_COLUMN_COUNT, 4'd8);
        push_matrix(-1);

        // Hold the receiver off at the end of one matrix and keep offering the next
        write_size(spom_pkg::CFG_ROW_COUNT, 4'd3);
        write_size(spom_pkg::CFG_COLUMN_COUNT, 4'd3);
        gaps_enabled = 1'b0;
        push_matrix(8);
        push_matrix(-1);

        // Random shapes and contents, with broken loads and stray writes mixed in
        while (items_pushed < ITEM_TARGET) begin
            gaps_enabled = ($urandom_range(0, 3) != 0);
            choice = $urandom_range(0, 9);
            if (choice < 3) begin
                write_size(spom_pkg::CFG_ROW_COUNT, pick_size_code());
                write_size(spom_pkg::CFG_COLUMN_COUNT, pick_size_code());
            end else if (choice == 3) begin
                write_register(CFG_FIRST_UNUSED
                               + spom_pkg::CFG_IDX_W'($urandom_range(0, 13)),
                               spom_pkg::SIZE_W'($urandom));
            end
            if (choice == 4 && shape_rows * shape_columns > 1) begin
                part = $urandom_range(1, shape_rows * shape_columns - 1);
                for (i = 0; i < part; i++) begin
                    push_element(random_word());
                end
                write_size($urandom_range(0, 1) ? spom_pkg::CFG_ROW_COUNT
                                                : spom_pkg::CFG_COLUMN_COUNT,
                           pick_size_code());
            end else begin
                push_matrix(($urandom_range(0, 9) == 0)
                            ? $urandom_range(0, shape_rows * shape_columns - 1) : -1);
            end
        end

        // Drain and give the verdict
        settle_block();
        if (mismatch_count == 0 && cells_outstanding == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
